FILE: rtl/iom_pkg.sv
// Shared types and constants of the inver-over move engine.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package iom_pkg;

    // default tour capacity
    localparam int DEF_MAX_CITIES = 256;

    // field widths
    localparam int CMD_W   = 2;
    localparam int CITY_W  = 8;
    localparam int CNT_W   = 9;
    localparam int DIST_W  = 16;
    localparam int DELTA_W = 18;
    localparam int ALU_W   = 19;

    // commands
    localparam logic [CMD_W-1:0] CMD_LOAD_TOUR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_DIST = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MOVE      = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ_TOUR = 2'd3;

    // configuration register map
    localparam int                 APB_ADDR_W       = 3;
    localparam logic               REG_CITY_COUNT   = 1'b0;
    localparam logic [CNT_W-1:0]   CITY_COUNT_RESET = 9'd256;

    // target position reported when the city is not in the tour
    localparam logic [CITY_W-1:0] POS_NOT_FOUND = 8'hFF;

    // shared adder/subtractor
    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef struct packed {
        logic                    op;
        logic signed [ALU_W-1:0] a;
        logic signed [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic signed [ALU_W-1:0] res;
        logic                    neg;
    } t_alu_rsp;

endpackage

FILE: rtl/inver_over_move_engine_core.sv
// Top level of the inver-over move engine: sequencer, tour and distance stores.
// Depends on iom_pkg, iom_alu (shared adder/subtractor) and iom_cfg (APB registers).
`timescale 1ns / 1ps

// Channel    Handshake                     Payload
// ---------  ----------------------------  ---------------------------------------------
// command    start / busy (start & !busy)  i_command, i_position, i_city, i_other_city,
//                                          i_distance
// result     o_result_valid, 1-cycle pulse o_city_out, o_target_position, o_adjacent,
//                                          o_delta, o_next_position
// config     APB psel/penable/pwrite       paddr, pwdata, prdata (pready tied high)
//
// Tour and distance loads keep busy low and give their result the next cycle; a tour
// read passes through ST_RD. A move reduces the position by repeated subtraction (one
// subtract a cycle), searches the tour in ST_SRCH_A and ST_SRCH_C per position, looks
// up the distances of edges a-x, b-y, a-b and x-y, then runs each swap of the reversal as
// a loop test, reads of tour[j] and tour[k] and writes of both on the tour store's ports.
// Reset is synchronous, active low, clears the sequencer and result strobe, sets the city
// count register to 256 only; both stores are undefined until written and never cleared.
// Results cannot be stalled: each is valid for one cycle, and busy drops in that cycle.

module inver_over_move_engine_core #(
    parameter int MAX_CITIES = iom_pkg::DEF_MAX_CITIES
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // command channel
    input  logic                                  start,
    output logic                                  busy,
    input  logic [iom_pkg::CMD_W-1:0]             i_command,
    input  logic [iom_pkg::CITY_W-1:0]            i_position,
    input  logic [iom_pkg::CITY_W-1:0]            i_city,
    input  logic [iom_pkg::CITY_W-1:0]            i_other_city,
    input  logic [iom_pkg::DIST_W-1:0]            i_distance,
    // result channel
    output logic                                  o_result_valid,
    output logic [iom_pkg::CITY_W-1:0]            o_city_out,
    output logic [iom_pkg::CITY_W-1:0]            o_target_position,
    output logic                                  o_adjacent,
    output logic signed [iom_pkg::DELTA_W-1:0]    o_delta,
    output logic [iom_pkg::CITY_W-1:0]            o_next_position,
    // configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [iom_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    localparam int TW  = $clog2(MAX_CITIES);
    localparam int DAW = 2 * TW;
    localparam int CAP = (MAX_CITIES < 256) ? MAX_CITIES : 256;
    localparam logic [iom_pkg::CNT_W-1:0] CAP_N = iom_pkg::CNT_W'(CAP);
    localparam logic [iom_pkg::CNT_W-1:0] MIN_N = 9'd3;

    // sequencer states
    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_RD     = 5'd1;
    localparam logic [4:0] ST_MOD    = 5'd2;
    localparam logic [4:0] ST_SRCH_A = 5'd3;
    localparam logic [4:0] ST_SRCH_C = 5'd4;
    localparam logic [4:0] ST_RDA    = 5'd5;
    localparam logic [4:0] ST_RDB    = 5'd6;
    localparam logic [4:0] ST_RDY    = 5'd7;
    localparam logic [4:0] ST_CAPY   = 5'd8;
    localparam logic [4:0] ST_DA     = 5'd9;
    localparam logic [4:0] ST_DB     = 5'd10;
    localparam logic [4:0] ST_DC     = 5'd11;
    localparam logic [4:0] ST_DD     = 5'd12;
    localparam logic [4:0] ST_DE     = 5'd13;
    localparam logic [4:0] ST_MODE   = 5'd14;
    localparam logic [4:0] ST_SW_CHK = 5'd15;
    localparam logic [4:0] ST_SW_R1  = 5'd16;
    localparam logic [4:0] ST_SW_R2  = 5'd17;
    localparam logic [4:0] ST_SW_W1  = 5'd18;
    localparam logic [4:0] ST_SW_W2  = 5'd19;

    // reversal shapes
    localparam logic [1:0] MODE_FWD  = 2'd0;  // plain span, no wrap
    localparam logic [1:0] MODE_HEAD = 2'd1;  // wrap, tail part not longer
    localparam logic [1:0] MODE_TAIL = 2'd2;  // wrap, head part shorter

    // ---------------------------------------------------------------- config
    logic [iom_pkg::CNT_W-1:0] city_count;
    logic [iom_pkg::CNT_W-1:0] n_eff;

    iom_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_city_count (city_count)
    );

    always_comb begin
        if (city_count < MIN_N) begin
            n_eff = MIN_N;
        end else if (city_count > CAP_N) begin
            n_eff = CAP_N;
        end else begin
            n_eff = city_count;
        end
    end

    // ---------------------------------------------------------------- stores
    logic [iom_pkg::CITY_W-1:0] r_tour_mem [MAX_CITIES];
    logic [iom_pkg::CITY_W-1:0] r_tour_q;
    logic                       tour_we;
    logic [TW-1:0]              tour_waddr;
    logic [TW-1:0]              tour_raddr;
    logic [iom_pkg::CITY_W-1:0] tour_wdata;

    always_ff @(posedge i_clk) begin
        if (tour_we) begin
            r_tour_mem[tour_waddr] <= tour_wdata;
        end
        r_tour_q <= r_tour_mem[tour_raddr];
    end

    logic [iom_pkg::DIST_W-1:0] r_dist_mem [2**DAW];
    logic [iom_pkg::DIST_W-1:0] r_dist_q;
    logic                       dist_we;
    logic [DAW-1:0]             dist_waddr;
    logic [DAW-1:0]             dist_raddr;

    always_ff @(posedge i_clk) begin
        if (dist_we) begin
            r_dist_mem[dist_waddr] <= i_distance;
        end
        r_dist_q <= r_dist_mem[dist_raddr];
    end

    function automatic logic city_ok(input logic [iom_pkg::CITY_W-1:0] u);
        return (32'(u) < MAX_CITIES);
    endfunction

    function automatic logic [DAW-1:0] pair(input logic [iom_pkg::CITY_W-1:0] u,
                                            input logic [iom_pkg::CITY_W-1:0] v);
        return {TW'(u), TW'(v)};
    endfunction

    // ---------------------------------------------------------------- shared unit
    iom_pkg::t_alu_req alu_req;
    iom_pkg::t_alu_rsp alu_rsp;

    iom_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // ---------------------------------------------------------------- sequencer
    logic [4:0]                        r_state, n_state;
    logic [iom_pkg::CNT_W-1:0]         r_p, n_p;        // current position
    logic [iom_pkg::CNT_W-1:0]         r_i, n_i;        // search index
    logic [iom_pkg::CITY_W-1:0]        r_t, n_t;        // target position
    logic [iom_pkg::CITY_W-1:0]        r_c, n_c;        // target city (= tour[t])
    logic [iom_pkg::CITY_W-1:0]        r_a, n_a;
    logic [iom_pkg::CITY_W-1:0]        r_b, n_b;
    logic [iom_pkg::CITY_W-1:0]        r_y, n_y;
    logic [iom_pkg::CITY_W-1:0]        r_tmp, n_tmp;
    logic signed [iom_pkg::ALU_W-1:0]  r_acc, n_acc;
    logic signed [9:0]                 r_j, n_j;
    logic signed [9:0]                 r_k, n_k;
    logic [1:0]                        r_mode, n_mode;
    logic                              r_phase, n_phase;
    logic                              r_dv, n_dv;      // distance lookup in range
    logic                              r_rd_ok, n_rd_ok;

    // result registers
    logic                              r_strobe, n_strobe;
    logic [iom_pkg::CITY_W-1:0]        r_city_out, n_city_out;
    logic [iom_pkg::CITY_W-1:0]        r_tpos, n_tpos;
    logic                              r_adj, n_adj;
    logic [iom_pkg::DELTA_W-1:0]       r_delta, n_delta;
    logic [iom_pkg::CITY_W-1:0]        r_nextp, n_nextp;

    logic [iom_pkg::CNT_W-1:0]         nextp, prevp, tnext;
    logic [9:0]                        span_sum;
    logic signed [iom_pkg::ALU_W-1:0]  dval;
    logic                              go;

    always_comb begin
        nextp    = (r_p + 9'd1 == n_eff) ? 9'd0 : r_p + 9'd1;
        prevp    = (r_p == 9'd0) ? n_eff - 9'd1 : r_p - 9'd1;
        tnext    = ({1'b0, r_t} + 9'd1 == n_eff) ? 9'd0 : {1'b0, r_t} + 9'd1;
        span_sum = {1'b0, r_p} + 10'({r_t}) + 10'd2;
        dval     = r_dv ? iom_pkg::ALU_W'(r_dist_q) : '0;
    end

    always_comb begin
        n_state    = r_state;
        n_p        = r_p;
        n_i        = r_i;
        n_t        = r_t;
        n_c        = r_c;
        n_a        = r_a;
        n_b        = r_b;
        n_y        = r_y;
        n_tmp      = r_tmp;
        n_acc      = r_acc;
        n_j        = r_j;
        n_k        = r_k;
        n_mode     = r_mode;
        n_phase    = r_phase;
        n_dv       = r_dv;
        n_rd_ok    = r_rd_ok;
        n_strobe   = 1'b0;
        n_city_out = r_city_out;
        n_tpos     = r_tpos;
        n_adj      = r_adj;
        n_delta    = r_delta;
        n_nextp    = r_nextp;

        tour_we    = 1'b0;
        tour_waddr = TW'(r_j[8:0]);
        tour_wdata = r_tour_q;
        tour_raddr = TW'(r_i);
        dist_we    = 1'b0;
        dist_waddr = pair(i_city, i_other_city);
        dist_raddr = pair(r_a, r_c);
        alu_req.op = iom_pkg::ALU_ADD;
        alu_req.a  = r_acc;
        alu_req.b  = dval;
        go         = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (i_command)
                        iom_pkg::CMD_LOAD_TOUR: begin
                            tour_we    = city_ok(i_position);
                            tour_waddr = TW'(i_position);
                            tour_wdata = i_city;
                            n_strobe   = 1'b1;
                            n_city_out = '0;
                            n_tpos     = '0;
                            n_adj      = 1'b0;
                            n_delta    = '0;
                            n_nextp    = '0;
                        end
                        iom_pkg::CMD_LOAD_DIST: begin
                            dist_we    = city_ok(i_city) && city_ok(i_other_city);
                            n_strobe   = 1'b1;
                            n_city_out = '0;
                            n_tpos     = '0;
                            n_adj      = 1'b0;
                            n_delta    = '0;
                            n_nextp    = '0;
                        end
                        iom_pkg::CMD_READ_TOUR: begin
                            tour_raddr = TW'(i_position);
                            n_rd_ok    = city_ok(i_position);
                            n_state    = ST_RD;
                        end
                        default: begin  // move
                            n_p     = {1'b0, i_position};
                            n_c     = i_city;
                            n_state = ST_MOD;
                        end
                    endcase
                end
            end

            ST_RD: begin
                n_strobe   = 1'b1;
                n_city_out = r_rd_ok ? r_tour_q : '0;
                n_tpos     = '0;
                n_adj      = 1'b0;
                n_delta    = '0;
                n_nextp    = '0;
                n_state    = ST_IDLE;
            end

            // position mod n by repeated subtraction
            ST_MOD: begin
                alu_req.op = iom_pkg::ALU_SUB;
                alu_req.a  = iom_pkg::ALU_W'(r_p);
                alu_req.b  = iom_pkg::ALU_W'(n_eff);
                if (!alu_rsp.neg) begin
                    n_p = alu_rsp.res[iom_pkg::CNT_W-1:0];
                end else begin
                    n_i     = '0;
                    n_state = ST_SRCH_A;
                end
            end

            ST_SRCH_A: begin
                tour_raddr = TW'(r_i);
                n_state    = ST_SRCH_C;
            end

            ST_SRCH_C: begin
                if (r_tour_q == r_c) begin
                    n_t = r_i[iom_pkg::CITY_W-1:0];
                    if (r_i == nextp || r_i == prevp) begin
                        n_strobe   = 1'b1;
                        n_city_out = '0;
                        n_tpos     = r_i[iom_pkg::CITY_W-1:0];
                        n_adj      = 1'b1;
                        n_delta    = '0;
                        n_nextp    = nextp[iom_pkg::CITY_W-1:0];
                        n_state    = ST_IDLE;
                    end else begin
                        n_state = ST_RDA;
                    end
                end else if (r_i == n_eff - 9'd1) begin
                    n_strobe   = 1'b1;
                    n_city_out = '0;
                    n_tpos     = iom_pkg::POS_NOT_FOUND;
                    n_adj      = 1'b0;
                    n_delta    = '0;
                    n_nextp    = nextp[iom_pkg::CITY_W-1:0];
                    n_state    = ST_IDLE;
                end else begin
                    n_i     = r_i + 9'd1;
                    n_state = ST_SRCH_A;
                end
            end

            // fetch the edge end cities
            ST_RDA: begin
                tour_raddr = TW'(r_p);
                n_state    = ST_RDB;
            end
            ST_RDB: begin
                tour_raddr = TW'(nextp);
                n_a        = r_tour_q;
                n_state    = ST_RDY;
            end
            ST_RDY: begin
                tour_raddr = TW'(tnext);
                n_b        = r_tour_q;
                n_state    = ST_CAPY;
            end
            ST_CAPY: begin
                n_y     = r_tour_q;
                n_state = ST_DA;
            end

            // delta = d[a][x] + d[b][y] - d[a][b] - d[x][y]
            ST_DA: begin
                dist_raddr = pair(r_a, r_c);
                n_dv       = city_ok(r_a) && city_ok(r_c);
                n_state    = ST_DB;
            end
            ST_DB: begin
                alu_req.a  = '0;
                n_acc      = alu_rsp.res;
                dist_raddr = pair(r_b, r_y);
                n_dv       = city_ok(r_b) && city_ok(r_y);
                n_state    = ST_DC;
            end
            ST_DC: begin
                n_acc      = alu_rsp.res;
                dist_raddr = pair(r_a, r_b);
                n_dv       = city_ok(r_a) && city_ok(r_b);
                n_state    = ST_DD;
            end
            ST_DD: begin
                alu_req.op = iom_pkg::ALU_SUB;
                n_acc      = alu_rsp.res;
                dist_raddr = pair(r_c, r_y);
                n_dv       = city_ok(r_c) && city_ok(r_y);
                n_state    = ST_DE;
            end
            ST_DE: begin
                alu_req.op = iom_pkg::ALU_SUB;
                n_acc      = alu_rsp.res;
                n_state    = ST_MODE;
            end

            // pick the reversal shape from p and t
            ST_MODE: begin
                n_phase = 1'b0;
                if (r_p < {1'b0, r_t}) begin
                    n_mode = MODE_FWD;
                    n_j    = 10'(r_p) + 10'sd1;
                    n_k    = 10'({1'b0, r_t});
                end else begin
                    n_mode = ({1'b0, n_eff} <= span_sum) ? MODE_HEAD : MODE_TAIL;
                    n_j    = 10'({1'b0, r_t});
                    n_k    = 10'(r_p) + 10'sd1;
                end
                n_state = ST_SW_CHK;
            end

            // loop test on the shared subtractor
            ST_SW_CHK: begin
                alu_req.op = iom_pkg::ALU_SUB;
                if (r_phase) begin
                    alu_req.a = iom_pkg::ALU_W'(r_j);
                    alu_req.b = iom_pkg::ALU_W'(r_k);
                    go        = !alu_rsp.neg;
                end else begin
                    case (r_mode)
                        MODE_FWD: begin
                            alu_req.a = iom_pkg::ALU_W'(r_k);
                            alu_req.b = iom_pkg::ALU_W'(r_j);
                            go        = !alu_rsp.neg;
                        end
                        MODE_HEAD: begin
                            alu_req.a = iom_pkg::ALU_W'(r_k);
                            alu_req.b = iom_pkg::ALU_W'(n_eff);
                            go        = alu_rsp.neg;
                        end
                        default: begin
                            alu_req.a = iom_pkg::ALU_W'(r_j);
                            alu_req.b = '0;
                            go        = !alu_rsp.neg;
                        end
                    endcase
                end

                if (go) begin
                    n_state = ST_SW_R1;
                end else if (!r_phase && r_mode == MODE_HEAD) begin
                    n_k     = '0;
                    n_phase = 1'b1;
                end else if (!r_phase && r_mode == MODE_TAIL) begin
                    n_j     = 10'(n_eff) - 10'sd1;
                    n_phase = 1'b1;
                end else begin
                    n_strobe   = 1'b1;
                    n_city_out = '0;
                    n_tpos     = r_t;
                    n_adj      = 1'b0;
                    n_delta    = r_acc[iom_pkg::DELTA_W-1:0];
                    n_nextp    = nextp[iom_pkg::CITY_W-1:0];
                    n_state    = ST_IDLE;
                end
            end

            // swap tour[j] and tour[k]
            ST_SW_R1: begin
                tour_raddr = TW'(r_j[8:0]);
                n_state    = ST_SW_R2;
            end
            ST_SW_R2: begin
                tour_raddr = TW'(r_k[8:0]);
                n_tmp      = r_tour_q;
                n_state    = ST_SW_W1;
            end
            ST_SW_W1: begin
                tour_we    = 1'b1;
                tour_waddr = TW'(r_j[8:0]);
                tour_wdata = r_tour_q;
                n_state    = ST_SW_W2;
            end
            ST_SW_W2: begin
                tour_we    = 1'b1;
                tour_waddr = TW'(r_k[8:0]);
                tour_wdata = r_tmp;
                if (r_mode == MODE_FWD) begin
                    n_j = r_j + 10'sd1;
                    n_k = r_k - 10'sd1;
                end else begin
                    n_j = r_j - 10'sd1;
                    n_k = r_k + 10'sd1;
                end
                n_state = ST_SW_CHK;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p        <= n_p;
        r_i        <= n_i;
        r_t        <= n_t;
        r_c        <= n_c;
        r_a        <= n_a;
        r_b        <= n_b;
        r_y        <= n_y;
        r_tmp      <= n_tmp;
        r_acc      <= n_acc;
        r_j        <= n_j;
        r_k        <= n_k;
        r_mode     <= n_mode;
        r_phase    <= n_phase;
        r_dv       <= n_dv;
        r_rd_ok    <= n_rd_ok;
        r_city_out <= n_city_out;
        r_tpos     <= n_tpos;
        r_adj      <= n_adj;
        r_delta    <= n_delta;
        r_nextp    <= n_nextp;
    end

    // ---------------------------------------------------------------- outputs
    assign busy              = (r_state != ST_IDLE);
    assign o_result_valid    = r_strobe;
    assign o_city_out        = r_city_out;
    assign o_target_position = r_tpos;
    assign o_adjacent        = r_adj;
    assign o_delta           = r_delta;
    assign o_next_position   = r_nextp;

endmodule

FILE: rtl/iom_alu.sv
// Shared add/subtract unit with sign flag.
// Depends on iom_pkg for the request and response structs.
`timescale 1ns / 1ps

module iom_alu (
    input  iom_pkg::t_alu_req i_req,
    output iom_pkg::t_alu_rsp o_rsp
);

    logic signed [iom_pkg::ALU_W-1:0] sum;

    always_comb begin
        if (i_req.op == iom_pkg::ALU_SUB) begin
            sum = i_req.a - i_req.b;
        end else begin
            sum = i_req.a + i_req.b;
        end
        o_rsp.res = sum;
        o_rsp.neg = sum[iom_pkg::ALU_W-1];
    end

endmodule

FILE: rtl/iom_cfg.sv
// APB register block holding the city count register.
// Depends on iom_pkg for the register map and reset value.
`timescale 1ns / 1ps

module iom_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [iom_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output logic [iom_pkg::CNT_W-1:0]      o_city_count
);

    logic [iom_pkg::CNT_W-1:0] r_city_count;
    logic                      sel_cc;

    assign sel_cc = (paddr[2] == iom_pkg::REG_CITY_COUNT);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_city_count <= iom_pkg::CITY_COUNT_RESET;
        end else if (psel && penable && pwrite && sel_cc) begin
            r_city_count <= pwdata[iom_pkg::CNT_W-1:0];
        end
    end

    always_comb begin
        if (sel_cc) begin
            prdata = {{(32 - iom_pkg::CNT_W){1'b0}}, r_city_count};
        end else begin
            prdata = 32'd0;
        end
    end

    assign o_city_count = r_city_count;

endmodule

FILE: test/inver_over_move_engine_core_tb.sv
// Self-checking testbench for inver_over_move_engine_core: tour/distance loads, tour reads
// and inver-over moves, each checked against an in-bench predictor of the engine.
// Depends on iom_pkg and the RTL of the engine; needs no files or arguments.
`timescale 1ns / 1ps

module inver_over_move_engine_core_tb;
    import iom_pkg::*;

    localparam int MAX_TOUR      = DEF_MAX_CITIES;
    localparam int MAX_USED      = 12;      // cities that ever appear in a tour
    localparam int SETTLE_CYCLES = 16;
    localparam logic [APB_ADDR_W-1:0] CITY_COUNT_ADDR = APB_ADDR_W'(4 * REG_CITY_COUNT);

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [CITY_W-1:0] position;
        logic [CITY_W-1:0] city;
        logic [CITY_W-1:0] other_city;
        logic [DIST_W-1:0] distance;
    } cmd_req_t;

    typedef struct packed {
        logic [CITY_W-1:0]  city_out;
        logic [CITY_W-1:0]  target_position;
        logic               adjacent;
        logic [DELTA_W-1:0] delta;
        logic [CITY_W-1:0]  next_position;
    } move_result_t;

    // ---------------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ---------------------------------------------------------------------------------
    logic                      i_clk        = 1'b0;
    logic                      i_rst_n      = 1'b0;
    logic                      start        = 1'b0;
    logic                      busy;
    logic [CMD_W-1:0]          i_command    = CMD_LOAD_TOUR;
    logic [CITY_W-1:0]         i_position   = '0;
    logic [CITY_W-1:0]         i_city       = '0;
    logic [CITY_W-1:0]         i_other_city = '0;
    logic [DIST_W-1:0]         i_distance   = '0;
    logic                      o_result_valid;
    logic [CITY_W-1:0]         o_city_out;
    logic [CITY_W-1:0]         o_target_position;
    logic                      o_adjacent;
    logic signed [DELTA_W-1:0] o_delta;
    logic [CITY_W-1:0]         o_next_position;
    logic                      psel         = 1'b0;
    logic                      penable      = 1'b0;
    logic                      pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0]     paddr        = '0;
    logic [31:0]               pwdata       = '0;
    logic [31:0]               prdata;
    logic                      pready;

    inver_over_move_engine_core #(
        .MAX_CITIES (MAX_TOUR)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_command         (i_command),
        .i_position        (i_position),
        .i_city            (i_city),
        .i_other_city      (i_other_city),
        .i_distance        (i_distance),
        .o_result_valid    (o_result_valid),
        .o_city_out        (o_city_out),
        .o_target_position (o_target_position),
        .o_adjacent        (o_adjacent),
        .o_delta           (o_delta),
        .o_next_position   (o_next_position),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------------------------
    // Predictor state: shadow copies of both stores and the city count register
    // ---------------------------------------------------------------------------------
    logic [CITY_W-1:0] tour_shadow [MAX_TOUR];
    logic [DIST_W-1:0] dist_shadow [MAX_TOUR * MAX_TOUR];
    logic [CNT_W-1:0]  count_shadow = CITY_COUNT_RESET;

    cmd_req_t     cmd_backlog[$];       // transactions waiting for the driver
    move_result_t awaited_results[$];   // predictions of transactions already accepted
    int           items_queued  = 0;
    int           results_seen  = 0;
    int           mismatches    = 0;
    int           burst_left    = 0;
    int           gap_left      = 0;

    // Stimulus bookkeeping: never let the engine look at a store entry not yet written
    logic [CITY_W-1:0] used_cities[$];
    bit                city_known   [MAX_TOUR];
    bit                tour_written [MAX_TOUR];

    // Count in use: register clamped into [3, capacity]
    function automatic int effective_cities(input logic [CNT_W-1:0] cnt_val);
        if (cnt_val < 3) return 3;
        if (cnt_val > MAX_TOUR) return MAX_TOUR;
        return int'(cnt_val);
    endfunction

    // Applies one accepted transaction to the shadow state and returns its result
    function automatic move_result_t compute_command_result(input cmd_req_t req);
        move_result_t      res;
        int                n, p, t, m, i, j, k;
        int                change;
        logic [CITY_W-1:0] a, b, x, y, held;
        res = '0;
        case (req.command)
            CMD_LOAD_TOUR: tour_shadow[req.position] = req.city;
            CMD_LOAD_DIST: dist_shadow[{req.city, req.other_city}] = req.distance;
            CMD_READ_TOUR: res.city_out = tour_shadow[req.position];
            CMD_MOVE: begin
                n = effective_cities(count_shadow);
                p = int'(req.position) % n;
                res.next_position = CITY_W'((p + 1) % n);
                // first position holding the target
                t = -1;
                for (i = 0; i < n && t < 0; i++)
                    if (tour_shadow[i] == req.city) t = i;
                if (t < 0) begin
                    res.target_position = POS_NOT_FOUND;
                end else begin
                    res.target_position = CITY_W'(t);
                    if ((p + 1) % n == t || (p - 1 + n) % n == t) begin
                        res.adjacent = 1'b1;
                    end else begin
                        a = tour_shadow[p];
                        b = tour_shadow[(p + 1) % n];
                        x = tour_shadow[t];
                        y = tour_shadow[(t + 1) % n];
                        change = int'(dist_shadow[{a, x}]) + int'(dist_shadow[{b, y}])
                               - int'(dist_shadow[{a, b}]) - int'(dist_shadow[{x, y}]);
                        res.delta = change[DELTA_W-1:0];
                        // reverse the cyclic span p+1 .. t; t == p turns the whole ring
                        m = (t - p - 1 + n) % n + 1;
                        for (i = 0; i < m / 2; i++) begin
                            j = (p + 1 + i) % n;
                            k = (p + m - i) % n;
                            held           = tour_shadow[j];
                            tour_shadow[j] = tour_shadow[k];
                            tour_shadow[k] = held;
                        end
                    end
                end
            end
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------------------------
    // Driver: bursts of transactions with random gaps; start held until accepted
    // ---------------------------------------------------------------------------------
    always @(posedge i_clk) begin : cmd_driver
        cmd_req_t nxt;
        bit       free;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            free = !start || !busy;
            if (start && !busy)
                awaited_results.push_back(compute_command_result(
                    '{i_command, i_position, i_city, i_other_city, i_distance}));
            if (free) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (cmd_backlog.size() != 0) begin
                    nxt = cmd_backlog.pop_front();
                    i_command    <= nxt.command;
                    i_position   <= nxt.position;
                    i_city       <= nxt.city;
                    i_other_city <= nxt.other_city;
                    i_distance   <= nxt.distance;
                    start        <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(24, 1);
                        // a third of bursts run straight into the next one
                        gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(12, 1);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Monitor: every strobed result is compared with the oldest prediction
    // ---------------------------------------------------------------------------------
    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 50)
                $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : result_monitor
        move_result_t want;
        if (i_rst_n && o_result_valid) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                mismatches++;
                $display("%0t ns: result expected none, got city 0x%0h target 0x%0h", $time,
                         o_city_out, o_target_position);
            end else begin
                want = awaited_results.pop_front();
                check_field("city_out", want.city_out, o_city_out);
                check_field("target_position", want.target_position, o_target_position);
                check_field("adjacent", want.adjacent, o_adjacent);
                check_field("delta", {14'b0, want.delta}, {14'b0, o_delta});
                check_field("next_position", want.next_position, o_next_position);
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Stimulus helpers; unused fields of a transaction always carry random bits
    // ---------------------------------------------------------------------------------
    function automatic cmd_req_t random_req(input logic [CMD_W-1:0] cmd);
        cmd_req_t r;
        r            = cmd_req_t'({$urandom(), $urandom()});
        r.command    = cmd;
        return r;
    endfunction

    function automatic logic [DIST_W-1:0] rand_distance();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return DIST_W'($urandom());
        endcase
    endfunction

    function automatic logic [CITY_W-1:0] pick_used();
        return used_cities[$urandom_range(used_cities.size() - 1)];
    endfunction

    task automatic queue_req(input cmd_req_t r);
        cmd_backlog.push_back(r);
        items_queued++;
    endtask

    task automatic push_tour_load(input logic [CITY_W-1:0] pos, input logic [CITY_W-1:0] c);
        cmd_req_t r;
        r          = random_req(CMD_LOAD_TOUR);
        r.position = pos;
        r.city     = c;
        tour_written[pos] = 1'b1;
        queue_req(r);
    endtask

    task automatic push_dist_load(input logic [CITY_W-1:0] c, input logic [CITY_W-1:0] oc,
                                  input logic [DIST_W-1:0] d);
        cmd_req_t r;
        r            = random_req(CMD_LOAD_DIST);
        r.city       = c;
        r.other_city = oc;
        r.distance   = d;
        queue_req(r);
    endtask

    task automatic push_move(input logic [CITY_W-1:0] pos, input logic [CITY_W-1:0] c);
        cmd_req_t r;
        r          = random_req(CMD_MOVE);
        r.position = pos;
        r.city     = c;
        queue_req(r);
    endtask

    task automatic push_read(input logic [CITY_W-1:0] pos);
        cmd_req_t r;
        r          = random_req(CMD_READ_TOUR);
        r.position = pos;
        queue_req(r);
    endtask

    // New tour city: fill in its distances to and from every city seen so far
    task automatic add_city();
        logic [CITY_W-1:0] c;
        do c = CITY_W'($urandom_range(MAX_TOUR - 1)); while (city_known[c]);
        city_known[c] = 1'b1;
        used_cities.push_back(c);
        foreach (used_cities[i]) begin
            push_dist_load(c, used_cities[i], rand_distance());
            if (used_cities[i] != c) push_dist_load(used_cities[i], c, rand_distance());
        end
    endtask

    // Block is idle here: every transaction accepted and answered
    task automatic drain_results();
        while (results_seen < items_queued) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_city_count(input logic [CNT_W-1:0] cnt_val);
        logic [31:0] word;
        word              = $urandom();
        word[CNT_W-1:0]   = cnt_val;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CITY_COUNT_ADDR;
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        count_shadow = cnt_val;
    endtask

    // One configuration phase: set the count, make sure the tour in use is loaded,
    // then a random mix dominated by moves. Ends fully drained, which also gives the
    // sender its pause until every outstanding result has arrived.
    task automatic run_phase(input logic [CNT_W-1:0] cnt_val, input int mixed);
        int n, off, i, pick;
        write_city_count(cnt_val);
        n = effective_cities(cnt_val);
        repeat ($urandom_range(2)) if (used_cities.size() < MAX_USED) add_city();
        // short tours are reloaded; one no longer than the palette is a rotation of it, so its cities are distinct
        off = $urandom_range(used_cities.size() - 1);
        for (i = 0; i < n; i++)
            if (!tour_written[i] || n <= 32)
                push_tour_load(CITY_W'(i), (n <= used_cities.size()) ?
                               used_cities[(off + i) % used_cities.size()] : pick_used());
        repeat (mixed) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                push_move(($urandom_range(3) != 0) ? CITY_W'($urandom_range(n - 1))
                                                   : CITY_W'($urandom()),
                          ($urandom_range(4) != 0) ? pick_used() : CITY_W'($urandom()));
            end else if (pick < 70) begin
                i = $urandom_range(MAX_TOUR - 1);
                if (!tour_written[i]) i = $urandom_range(n - 1);
                push_read(CITY_W'(i));
            end else if (pick < 85) begin
                // stray distance writes are harmless noise
                if ($urandom_range(1)) push_dist_load(pick_used(), pick_used(), rand_distance());
                else push_dist_load(CITY_W'($urandom()), CITY_W'($urandom()), rand_distance());
            end else begin
                push_tour_load(CITY_W'($urandom_range(MAX_TOUR - 1)), pick_used());
            end
        end
        drain_results();
    endtask

    // ---------------------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------------------
    initial begin : stimulus
        logic [CNT_W-1:0] phase_counts [8];
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part on a three-city ring (count below minimum, clamped).
        // Only self distances of cities 00 and FF are large, so a move that wraps
        // the whole ring gives the largest positive delta.
        write_city_count(9'd1);
        used_cities = '{8'h00, 8'hFF, 8'hA5};
        foreach (used_cities[i]) city_known[used_cities[i]] = 1'b1;
        foreach (used_cities[i])
            foreach (used_cities[j])
                push_dist_load(used_cities[i], used_cities[j],
                    (i == j && used_cities[i] != 8'hA5) ? 16'hFFFF : 16'h0000);
        push_tour_load(8'd0, 8'h00);
        push_tour_load(8'd1, 8'hFF);
        push_tour_load(8'd2, 8'hA5);
        push_move(8'd0, 8'hFF);     // target one position ahead
        push_move(8'd0, 8'hA5);     // target one position behind (wraps)
        push_move(8'd1, 8'h3C);     // target absent from the tour
        push_move(8'd0, 8'h00);     // target at the current position
        push_move(8'hFF, 8'h00);    // position beyond the count
        push_read(8'd0);
        push_read(8'd1);
        push_read(8'd2);
        // flip the table so the same kind of move gives the most negative delta
        push_dist_load(8'hFF, 8'hFF, 16'h0000);
        push_dist_load(8'h00, 8'h00, 16'h0000);
        push_dist_load(8'hFF, 8'h00, 16'hFFFF);
        push_move(8'd0, 8'hFF);
        drain_results();

        // Random phases: clamp at the top, clamp at the bottom, exact minimum,
        // full capacity, another clamp at the bottom, and a few ordinary sizes.
        phase_counts[0] = 9'd511;
        phase_counts[1] = 9'd0;
        phase_counts[2] = 9'd3;
        phase_counts[3] = 9'd256;
        phase_counts[4] = 9'd2;
        phase_counts[5] = CNT_W'($urandom_range(24, 4));
        phase_counts[6] = CNT_W'($urandom_range(24, 4));
        phase_counts[7] = CNT_W'($urandom_range(255, 33));
        foreach (phase_counts[ph]) run_phase(phase_counts[ph], 40);

        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("inver_over_move_engine_core_tb passed");
        end else begin
            $display("inver_over_move_engine_core_tb failed");
        end
        $finish;
    end

    // Slowest legal run is well under a millisecond of simulated time
    initial begin : watchdog
        #5_000_000;
        $display("inver_over_move_engine_core_tb failed");
        $finish;
    end

endmodule
